// ===== sv/pros_pkg.sv =====
// Shared types, constants and defaults for the prefetch ring over stack block.
package pros_pkg;

    localparam int RING_DEPTH_DEF  = 128;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int VALUE_W    = 32;
    localparam int THR_W      = 6;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [THR_W-1:0]      THR_RESET = THR_W'(32);
    localparam logic [APB_ADDR_W-1:0] ADDR_THR  = APB_ADDR_W'(0);

    localparam logic OP_PUSH     = 1'b0;
    localparam logic OP_POP      = 1'b1;
    localparam logic KIND_HINT   = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_HINT,
        S_FAST_PUT,
        S_REF_PUT,
        S_TAKE,
        S_ANS
    } t_state;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_ring_ctl;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

// ===== sv/pros_ring.sv =====
// Prefetch ring: FIFO memory with head, tail and occupancy count.
module pros_ring #(
    parameter int RING_DEPTH  = 128,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pros_pkg::t_ring_ctl               i_ctl,
    input  logic [ENTRY_WIDTH-1:0]            i_wdata,
    output logic [ENTRY_WIDTH-1:0]            o_rdata,
    output logic [$clog2(RING_DEPTH+1)-1:0]   o_count,
    output logic                              o_full
);
    import pros_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    logic [ENTRY_WIDTH-1:0] r_mem [RING_DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rdata;
    logic [AW-1:0]          r_head;
    logic [AW-1:0]          r_tail;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          n_head;
    logic [AW-1:0]          n_tail;

    assign n_head = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign n_tail = (r_tail == AW'(RING_DEPTH - 1)) ? '0 : r_tail + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctl.wr) begin
                r_tail <= n_tail;
            end
            if (i_ctl.rd) begin
                r_head <= n_head;
            end
            case ({i_ctl.wr, i_ctl.rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[r_head];
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;
    assign o_full  = (r_count == CW'(RING_DEPTH));

endmodule

// ===== sv/pros_stack.sv =====
// Spill stack: LIFO memory with top-of-stack pointer.
module pros_stack #(
    parameter int STACK_DEPTH = 1024,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pros_pkg::t_stack_ctl   i_ctl,
    input  logic [ENTRY_WIDTH-1:0] i_wdata,
    output logic [ENTRY_WIDTH-1:0] o_rdata,
    output logic                   o_empty,
    output logic                   o_full
);
    import pros_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    logic [ENTRY_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rdata;
    logic [TW-1:0]          r_top;
    logic [TW-1:0]          top_m1;

    assign top_m1 = r_top - TW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0;
        end else if (i_ctl.push) begin
            r_top <= r_top + TW'(1);
        end else if (i_ctl.pop) begin
            r_top <= top_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_top[AW-1:0]] <= i_wdata;
        end
        if (i_ctl.pop) begin
            r_rdata <= r_mem[top_m1[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
    assign o_empty = (r_top == '0);
    assign o_full  = (r_top == TW'(STACK_DEPTH));

endmodule

// ===== sv/pros_seq.sv =====
// Sequencer: decodes items, drives ring and stack accesses, holds the result register.
module pros_seq #(
    parameter int RING_DEPTH  = 128,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic [pros_pkg::VALUE_W-1:0]      i_entry_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_result_kind,
    output logic [pros_pkg::VALUE_W-1:0]      o_result_value,
    output logic                              o_pop_valid,
    output logic                              o_overflow,
    output logic                              o_last,
    input  logic [pros_pkg::THR_W-1:0]        i_thr,
    input  logic [$clog2(RING_DEPTH+1)-1:0]   i_ring_count,
    input  logic                              i_ring_full,
    input  logic [ENTRY_WIDTH-1:0]            i_ring_rdata,
    input  logic                              i_stack_empty,
    input  logic                              i_stack_full,
    input  logic [ENTRY_WIDTH-1:0]            i_stack_rdata,
    output pros_pkg::t_ring_ctl               o_ring_ctl,
    output logic [ENTRY_WIDTH-1:0]            o_ring_wdata,
    output pros_pkg::t_stack_ctl              o_stack_ctl,
    output logic [ENTRY_WIDTH-1:0]            o_stack_wdata
);
    import pros_pkg::*;

    localparam int CW = $clog2(RING_DEPTH + 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [ENTRY_WIDTH-1:0] r_push_val;
    logic [ENTRY_WIDTH-1:0] n_push_val;
    logic                   r_ovf;
    logic                   n_ovf;
    logic                   r_ans_valid;
    logic                   n_ans_valid;

    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [VALUE_W-1:0]     r_out_value;
    logic                   r_out_pop_valid;
    logic                   r_out_ovf;
    logic                   r_out_last;

    logic                   slot_free;
    logic                   accept;
    logic                   emit;
    logic                   emit_kind;
    logic [VALUE_W-1:0]     emit_value;
    logic                   pop_fast;
    logic                   refill_more;
    logic [ENTRY_WIDTH-1:0] in_entry;

    assign slot_free   = !r_out_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE) || ((r_state == S_ANS) && slot_free);
    assign accept      = i_valid && o_ready;
    assign pop_fast    = (i_ring_count >= CW'(i_thr));
    assign refill_more = ((i_ring_count + CW'(1)) < CW'(i_thr)) && !i_stack_empty;
    assign in_entry    = ENTRY_WIDTH'(i_entry_value);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_ANS: begin
                if (r_state == S_ANS && slot_free) begin
                    n_state = S_IDLE;
                end
                if (accept) begin
                    if (i_opcode == OP_PUSH) begin
                        n_state = i_ring_full ? S_ANS : S_PUSH_HINT;
                    end else if (pop_fast) begin
                        n_state = i_stack_empty ? S_ANS : S_FAST_PUT;
                    end else if (!i_stack_empty) begin
                        n_state = S_REF_PUT;
                    end else begin
                        n_state = S_ANS;
                    end
                end
            end
            S_PUSH_HINT, S_FAST_PUT: begin
                if (slot_free) begin
                    n_state = S_ANS;
                end
            end
            S_REF_PUT: begin
                if (slot_free && !refill_more) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                n_state = S_ANS;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ring_ctl    = '0;
        o_stack_ctl   = '0;
        o_ring_wdata  = in_entry;
        o_stack_wdata = in_entry;
        emit          = 1'b0;
        emit_kind     = KIND_HINT;
        emit_value    = '0;
        n_push_val    = r_push_val;
        n_ovf         = r_ovf;
        n_ans_valid   = r_ans_valid;

        unique case (r_state)
            S_IDLE, S_ANS: begin
                if (r_state == S_ANS && slot_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ANSWER;
                    emit_value = r_ans_valid ? VALUE_W'(i_ring_rdata) : '0;
                end
                if (accept) begin
                    n_push_val = in_entry;
                    n_ovf      = 1'b0;
                    if (i_opcode == OP_PUSH) begin
                        n_ans_valid = 1'b0;
                        if (!i_ring_full) begin
                            o_ring_ctl.wr = 1'b1;
                        end else if (!i_stack_full) begin
                            o_stack_ctl.push = 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (pop_fast) begin
                        n_ans_valid    = 1'b1;
                        o_ring_ctl.rd  = 1'b1;
                        o_stack_ctl.pop = !i_stack_empty;
                    end else if (!i_stack_empty) begin
                        n_ans_valid     = 1'b1;
                        o_stack_ctl.pop = 1'b1;
                    end else begin
                        n_ans_valid   = (i_ring_count != '0);
                        o_ring_ctl.rd = (i_ring_count != '0);
                    end
                end
            end
            S_PUSH_HINT: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_value = VALUE_W'(r_push_val);
                end
            end
            S_FAST_PUT, S_REF_PUT: begin
                o_ring_wdata = i_stack_rdata;
                if (slot_free) begin
                    emit          = 1'b1;
                    emit_value    = VALUE_W'(i_stack_rdata);
                    o_ring_ctl.wr = 1'b1;
                    if (r_state == S_REF_PUT && refill_more) begin
                        o_stack_ctl.pop = 1'b1;
                    end
                end
            end
            S_TAKE: begin
                o_ring_ctl.rd = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_push_val  <= n_push_val;
        r_ovf       <= n_ovf;
        r_ans_valid <= n_ans_valid;
        if (emit) begin
            r_out_kind      <= emit_kind;
            r_out_value     <= emit_value;
            r_out_pop_valid <= (emit_kind == KIND_ANSWER) && r_ans_valid;
            r_out_ovf       <= (emit_kind == KIND_ANSWER) && r_ovf;
            r_out_last      <= (emit_kind == KIND_ANSWER);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_result_value = r_out_value;
    assign o_pop_valid    = r_out_pop_valid;
    assign o_overflow     = r_out_ovf;
    assign o_last         = r_out_last;

endmodule

// ===== sv/prefetch_ring_over_stack_top.sv =====
// Top level of the prefetch ring over stack work list.
//
// Input channel (i_valid/o_ready) carries one item: i_opcode push or pop, i_entry_value.
// Output channel (o_valid/i_ready) carries the results of each item in order: one prefetch
// hint for every entry that enters the ring, then the answer with o_last set.
// The threshold register sits at APB address 0; write it only while the block is idle.
// Steps per item, behind the registered memory reads and the single output register:
//   push into the ring: a hint, then the answer; push onto the stack or dropped: answer only
//   pop at or above threshold: ring head read, stack top moved into the ring with a hint,
//   then the answer; either pop with the stack empty: answer only
//   pop below threshold: stack entries move into the ring, each with a hint, until the ring
//   reaches the threshold or the stack empties, then the ring head is read, then the answer
// The first result is registered in the state the transfer leads to, once the slot is free.
// After reset the ring and stack are empty and the threshold is 32; no clearing pass.
// When the receiver stalls, the pending result holds and the sequencer waits;
// a new item is taken in the same cycle its predecessor's answer is registered.
module prefetch_ring_over_stack_top #(
    parameter int RING_DEPTH  = pros_pkg::RING_DEPTH_DEF,
    parameter int STACK_DEPTH = pros_pkg::STACK_DEPTH_DEF,
    parameter int ENTRY_WIDTH = pros_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [pros_pkg::VALUE_W-1:0]        i_entry_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_result_kind,
    output logic [pros_pkg::VALUE_W-1:0]        o_result_value,
    output logic                                o_pop_valid,
    output logic                                o_overflow,
    output logic                                o_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pros_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pros_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pros_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import pros_pkg::*;

    localparam int CW = $clog2(RING_DEPTH + 1);

    logic [THR_W-1:0]       r_thr;
    logic [THR_W-1:0]       thr_eff;
    t_ring_ctl              ring_ctl;
    t_stack_ctl             stack_ctl;
    logic [ENTRY_WIDTH-1:0] ring_wdata;
    logic [ENTRY_WIDTH-1:0] ring_rdata;
    logic [ENTRY_WIDTH-1:0] stack_wdata;
    logic [ENTRY_WIDTH-1:0] stack_rdata;
    logic [CW-1:0]          ring_count;
    logic                   ring_full;
    logic                   stack_empty;
    logic                   stack_full;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_THR)) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign prdata  = (paddr == ADDR_THR) ? APB_DATA_W'(r_thr) : '0;
    assign thr_eff = (r_thr == '0) ? THR_W'(1) : r_thr;

    pros_seq #(
        .RING_DEPTH  (RING_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_entry_value  (i_entry_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_kind  (o_result_kind),
        .o_result_value (o_result_value),
        .o_pop_valid    (o_pop_valid),
        .o_overflow     (o_overflow),
        .o_last         (o_last),
        .i_thr          (thr_eff),
        .i_ring_count   (ring_count),
        .i_ring_full    (ring_full),
        .i_ring_rdata   (ring_rdata),
        .i_stack_empty  (stack_empty),
        .i_stack_full   (stack_full),
        .i_stack_rdata  (stack_rdata),
        .o_ring_ctl     (ring_ctl),
        .o_ring_wdata   (ring_wdata),
        .o_stack_ctl    (stack_ctl),
        .o_stack_wdata  (stack_wdata)
    );

    pros_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .i_wdata (ring_wdata),
        .o_rdata (ring_rdata),
        .o_count (ring_count),
        .o_full  (ring_full)
    );

    pros_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stack_ctl),
        .i_wdata (stack_wdata),
        .o_rdata (stack_rdata),
        .o_empty (stack_empty),
        .o_full  (stack_full)
    );

endmodule

// ===== sv/pros_checker.sv =====
// Port-level checker for the prefetch ring over stack top level, with its bind.
module pros_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_ready,
    input logic                           o_valid,
    input logic                           o_result_kind,
    input logic [pros_pkg::VALUE_W-1:0]   o_result_value,
    input logic                           o_pop_valid,
    input logic                           o_overflow,
    input logic                           o_last
);
    import pros_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value) && $stable(o_last))
        else $error("result changed while stalled");

    a_hint_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_HINT) |-> !o_last && !o_pop_valid && !o_overflow)
        else $error("hint carries answer flags");

    a_answer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_ANSWER) |-> o_last)
        else $error("answer without last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_ANSWER) && !o_pop_valid |->
            (o_result_value == '0) && !(o_pop_valid && o_overflow))
        else $error("answer without entry has nonzero value");

endmodule

bind prefetch_ring_over_stack_top pros_checker u_pros_checker (.*);
